[hw/rtl/dequ_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dequ_pkg;

    // Ring geometry
    localparam int DEPTH  = 16;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int WORD_W = 32;
    localparam int ACT_W  = 3;
    localparam int OCC_W  = 5;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [ACT_W-1:0]         t_act;
    typedef logic [OCC_W-1:0]         t_occ;

    // Action codes
    localparam t_act ACT_PUSH_FRONT = 3'd0;
    localparam t_act ACT_PUSH_BACK  = 3'd1;
    localparam t_act ACT_POP_FRONT  = 3'd2;
    localparam t_act ACT_POP_BACK   = 3'd3;
    localparam t_act ACT_SEARCH     = 3'd4;

    // Advance a ring index by an offset below DEPTH, wrap at DEPTH.
    function automatic t_idx ring_add(input t_idx base, input t_idx offset);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (IDX_W+1)'(DEPTH)) begin
            sum = sum - (IDX_W+1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Step a ring index back by one, wrap at zero.
    function automatic t_idx ring_dec(input t_idx base);
        t_idx res;
        if (base == '0) begin
            res = IDX_W'(DEPTH - 1);
        end else begin
            res = base - IDX_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/double_ended_queue_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of signed 32-bit words held in a ring of DEPTH
// slots in one synchronous RAM (one write port, one registered read port).
// Issue a beat by raising start with i_action and i_value while busy is low.
// Every beat returns exactly one result, shown for one cycle with o_done high;
// the receiver cannot hold it off, so sample it on that cycle. For pushes, unused
// actions, pops of an empty or single-entry queue and searches of an empty
// queue, o_done rises in the cycle after the beat and busy stays low. A pop
// that leaves one or more entries passes through S_LOAD while busy is high,
// since the new front or back word must be fetched through the RAM read port.
// A search of a non-empty queue walks the live entries front to back one per
// cycle through the same port and stops at the first match; busy is high
// until its result appears. The front and back words read 0 when the queue
// is empty, a push into a full queue is dropped and flags overflow, and a pop
// of an empty queue changes nothing. No clearing pass follows reset.
module double_ended_queue_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire dequ_pkg::t_act  i_action,
    input  wire dequ_pkg::t_word i_value,
    output logic                o_done,
    output dequ_pkg::t_word     o_front_word,
    output dequ_pkg::t_word     o_back_word,
    output dequ_pkg::t_occ      o_occupancy,
    output logic                o_is_empty,
    output logic                o_found,
    output logic                o_overflow
);

    import dequ_pkg::*;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;   // wait for a refetched end word
    localparam logic [1:0] S_SRCH = 2'd2;   // compare one slot per cycle

    logic [1:0] r_state, n_state;
    t_idx       r_front, n_front;
    t_cnt       r_count, n_count;
    t_word      r_front_word, n_front_word;   // cached copy of the front slot
    t_word      r_back_word, n_back_word;     // cached copy of the back slot
    t_word      r_key, n_key;
    t_cnt       r_idx, n_idx;                 // next search offset to fetch
    logic       r_pop_front, n_pop_front;
    logic       r_done, n_done;
    logic       r_found, n_found;
    logic       r_overflow, n_overflow;

    logic       w_we;
    t_idx       w_waddr;
    t_idx       w_raddr;
    t_word      w_rdata;
    logic       w_full;
    logic       w_accept;

    dequ_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_front_word = r_front_word;
        n_back_word  = r_back_word;
        n_key        = r_key;
        n_idx        = r_idx;
        n_pop_front  = r_pop_front;
        n_done       = 1'b0;
        n_found      = 1'b0;
        n_overflow   = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_front;
        w_raddr      = r_front;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_action)
                        ACT_PUSH_FRONT: begin
                            n_done = 1'b1;
                            if (w_full) begin
                                n_overflow = 1'b1;
                            end else begin
                                w_we         = 1'b1;
                                w_waddr      = ring_dec(r_front);
                                n_front      = ring_dec(r_front);
                                n_count      = r_count + CNT_W'(1);
                                n_front_word = i_value;
                                if (r_count == '0) begin
                                    n_back_word = i_value;
                                end
                            end
                        end
                        ACT_PUSH_BACK: begin
                            n_done = 1'b1;
                            if (w_full) begin
                                n_overflow = 1'b1;
                            end else begin
                                w_we        = 1'b1;
                                w_waddr     = ring_add(r_front, r_count[IDX_W-1:0]);
                                n_count     = r_count + CNT_W'(1);
                                n_back_word = i_value;
                                if (r_count == '0) begin
                                    n_front_word = i_value;
                                end
                            end
                        end
                        ACT_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_front = ring_add(r_front, IDX_W'(1));
                                n_count = r_count - CNT_W'(1);
                                if (r_count == CNT_W'(1)) begin
                                    n_done = 1'b1;
                                end else begin
                                    // Fetch the new front word.
                                    w_raddr     = ring_add(r_front, IDX_W'(1));
                                    n_pop_front = 1'b1;
                                    n_state     = S_LOAD;
                                end
                            end
                        end
                        ACT_POP_BACK: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                if (r_count == CNT_W'(1)) begin
                                    n_done = 1'b1;
                                end else begin
                                    // Fetch the new back word.
                                    w_raddr     = ring_add(r_front,
                                                  t_idx'(r_count - CNT_W'(2)));
                                    n_pop_front = 1'b0;
                                    n_state     = S_LOAD;
                                end
                            end
                        end
                        ACT_SEARCH: begin
                            if (r_count == '0) begin
                                n_done = 1'b1;
                            end else begin
                                w_raddr = r_front;
                                n_key   = i_value;
                                n_idx   = CNT_W'(1);
                                n_state = S_SRCH;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                if (r_pop_front) begin
                    n_front_word = w_rdata;
                end else begin
                    n_back_word = w_rdata;
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_SRCH: begin
                // w_rdata holds the slot at offset r_idx - 1.
                if (w_rdata == r_key) begin
                    n_found = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_idx == r_count) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_raddr = ring_add(r_front, r_idx[IDX_W-1:0]);
                    n_idx   = r_idx + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_front    <= '0;
            r_count    <= '0;
            r_done     <= 1'b0;
            r_found    <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_front    <= n_front;
            r_count    <= n_count;
            r_done     <= n_done;
            r_found    <= n_found;
            r_overflow <= n_overflow;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_front_word <= n_front_word;
        r_back_word  <= n_back_word;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_pop_front  <= n_pop_front;
    end

    // The state registers already hold the post-step values during the
    // strobe cycle; the next beat cannot change them before it ends.
    assign o_done       = r_done;
    assign o_front_word = (r_count == '0) ? '0 : r_front_word;
    assign o_back_word  = (r_count == '0) ? '0 : r_back_word;
    assign o_occupancy  = OCC_W'(r_count);
    assign o_is_empty   = (r_count == '0);
    assign o_found      = r_found;
    assign o_overflow   = r_overflow;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_overflow |-> (r_count == CNT_W'(DEPTH)))
        else $error("overflow flagged on a queue that is not full");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_found && r_overflow))
        else $error("found and overflow raised together");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_IDLE))
        else $error("slot write while a fetch or search is in flight");

    a_search_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_idx != '0 && r_idx <= r_count))
        else $error("search offset outside the live entries");
`endif

endmodule

`default_nettype wire

[hw/rtl/dequ_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module dequ_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[test/double_ended_queue_unit_tb.sv]
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;
    import dequ_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RST_CYCLES  = 11;
    localparam int RAND_BEATS  = 1100;
    localparam int CHUNK       = 50;
    localparam int MAX_GAP     = 12;
    localparam int DRAIN_WAIT  = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 12;

    // Action codes the block treats as no-ops
    localparam t_act ACT_SPARE_5 = 3'd5;
    localparam t_act ACT_SPARE_6 = 3'd6;
    localparam t_act ACT_SPARE_7 = 3'd7;

    // Traffic shapes for the random part
    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} t_mode;

    // One result as the block reports it
    typedef struct packed {
        t_word front;
        t_word back;
        t_occ  occ;
        logic  empty;
        logic  found;
        logic  overflow;
    } t_view;

    // Predict the deque after each beat and hold the views still to come.
    class deque_scoreboard;
        t_word       ring[DEPTH];
        int unsigned head;
        int unsigned fill;
        t_view       pending_views[$];
        int          errors;

        function new();
            head   = 0;
            fill   = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("tb: mismatch: %s", msg);
            errors++;
        endtask

        function void note_beat(t_act act, t_word val);
            t_view exp_view;
            int unsigned k;
            exp_view = '0;
            case (act)
                ACT_PUSH_FRONT: begin
                    if (fill >= DEPTH) begin
                        exp_view.overflow = 1'b1;
                    end else begin
                        head       = (head + DEPTH - 1) % DEPTH;
                        ring[head] = val;
                        fill++;
                    end
                end
                ACT_PUSH_BACK: begin
                    if (fill >= DEPTH) begin
                        exp_view.overflow = 1'b1;
                    end else begin
                        ring[(head + fill) % DEPTH] = val;
                        fill++;
                    end
                end
                ACT_POP_FRONT: begin
                    if (fill > 0) begin
                        head = (head + 1) % DEPTH;
                        fill--;
                    end
                end
                ACT_POP_BACK: begin
                    if (fill > 0) begin
                        fill--;
                    end
                end
                ACT_SEARCH: begin
                    for (k = 0; k < fill; k++) begin
                        if (ring[(head + k) % DEPTH] == val) begin
                            exp_view.found = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            if (fill > 0) begin
                exp_view.front = ring[head];
                exp_view.back  = ring[(head + fill - 1) % DEPTH];
            end
            exp_view.occ   = t_occ'(fill);
            exp_view.empty = (fill == 0);
            pending_views.insert(pending_views.size(), exp_view);
        endfunction

        task check_view(t_view got);
            t_view exp_view;
            if (pending_views.size() == 0) begin
                report("result with no beat outstanding");
            end else begin
                exp_view = pending_views[0];
                pending_views.delete(0);
                if (got.front !== exp_view.front)
                    report($sformatf("front_word got %0d exp %0d", got.front, exp_view.front));
                if (got.back !== exp_view.back)
                    report($sformatf("back_word got %0d exp %0d", got.back, exp_view.back));
                if (got.occ !== exp_view.occ)
                    report($sformatf("occupancy got %0d exp %0d", got.occ, exp_view.occ));
                if (got.empty !== exp_view.empty)
                    report($sformatf("is_empty got %b exp %b", got.empty, exp_view.empty));
                if (got.found !== exp_view.found)
                    report($sformatf("found got %b exp %b", got.found, exp_view.found));
                if (got.overflow !== exp_view.overflow)
                    report($sformatf("overflow got %b exp %b", got.overflow,
                                     exp_view.overflow));
            end
        endtask
    endclass

    // Clock, reset and the block's ports; every input starts at a known value
    logic  i_clk    = 1'b0;
    logic  i_rst_n  = 1'b0;
    logic  start    = 1'b0;
    t_act  i_action = ACT_PUSH_FRONT;
    t_word i_value  = '0;
    logic  busy;
    logic  o_done;
    t_word o_front_word;
    t_word o_back_word;
    t_occ  o_occupancy;
    logic  o_is_empty;
    logic  o_found;
    logic  o_overflow;

    deque_scoreboard sb;
    t_word           word_pool[POOL_SIZE];
    int              cycle_count = 0;

    double_ended_queue_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_value     (i_value),
        .o_done      (o_done),
        .o_front_word(o_front_word),
        .o_back_word (o_back_word),
        .o_occupancy (o_occupancy),
        .o_is_empty  (o_is_empty),
        .o_found     (o_found),
        .o_overflow  (o_overflow)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Abort a hung run; the limit sits far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Catch each result on the cycle its strobe is high. Values read here are
    // the ones from before this edge, so the order of processes does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_view({o_front_word, o_back_word, o_occupancy,
                           o_is_empty, o_found, o_overflow});
        end
    end

    // Issue one beat after an idle gap. Start is left high on return so a
    // zero gap runs beats back to back; this task lowers it only when a gap follows.
    task automatic send_beat(t_act act, t_word val, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_action <= act;
        i_value  <= val;
        // Hold until an edge sees start with busy low: that edge takes the beat
        do begin
            @(posedge i_clk);
        end while (busy);
        sb.note_beat(act, val);
    endtask

    // Drop start and hold off until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_views.size() != 0) @(posedge i_clk);
    endtask

    // Favor words from a small pool so searches hit; mix in full random words
    // and the signed extremes so every bit toggles.
    function automatic t_word pick_word();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return word_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (sel == 5) return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
        return t_word'($urandom());
    endfunction

    // Bias toward pushes or pops so the ring spends time both full and empty
    function automatic t_act pick_action(t_mode mode);
        int unsigned roll;
        int unsigned push_pct;
        int unsigned pop_pct;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  begin push_pct = 65; pop_pct = 15; end
            MODE_DRAIN: begin push_pct = 15; pop_pct = 65; end
            default:    begin push_pct = 38; pop_pct = 38; end
        endcase
        if (roll < push_pct)
            return ($urandom_range(0, 1) != 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        if (roll < push_pct + pop_pct)
            return ($urandom_range(0, 1) != 0) ? ACT_POP_FRONT : ACT_POP_BACK;
        if (roll < 96)
            return ACT_SEARCH;
        case ($urandom_range(0, 2))
            0:       return ACT_SPARE_5;
            1:       return ACT_SPARE_6;
            default: return ACT_SPARE_7;
        endcase
    endfunction

    initial begin
        t_mode mode;
        bit    idle_on;
        int    n;

        sb = new();
        for (n = 0; n < POOL_SIZE; n++) word_pool[n] = t_word'($urandom());

        // Hold reset, then release it on an edge
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty queue: pops do nothing, search misses, spare codes report state
        send_beat(ACT_POP_FRONT, 32'sd5, 0);
        send_beat(ACT_POP_BACK, 32'sd5, 0);
        send_beat(ACT_SEARCH, 32'sd0, 1);
        send_beat(ACT_SPARE_5, 32'sd0, 0);
        send_beat(ACT_SPARE_7, -32'sd1, 2);

        // Extremes at both ends, then a hit and a miss
        send_beat(ACT_PUSH_FRONT, 32'sh80000000, 0);
        send_beat(ACT_PUSH_BACK, 32'sh7fffffff, 0);
        send_beat(ACT_SEARCH, 32'sh7fffffff, 0);
        send_beat(ACT_SEARCH, 32'sd12345, 3);

        // Fill to the brim from alternating ends, then push into a full ring
        for (n = 0; n < DEPTH - 2; n++) begin
            send_beat((n % 2 == 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                      (n == 0) ? 32'sd0 : (n == 1) ? -32'sd1 : t_word'($urandom()), 0);
        end
        send_beat(ACT_PUSH_FRONT, 32'sd77, 1);
        send_beat(ACT_PUSH_BACK, 32'sd78, 0);
        send_beat(ACT_POP_FRONT, 32'sd0, 0);
        send_beat(ACT_POP_BACK, 32'sd0, 0);

        // Pause the sender until every result is in
        drain_results();

        // Random traffic in chunks, each with its own shape and idling
        mode    = MODE_MIXED;
        idle_on = 1'b1;
        for (n = 0; n < RAND_BEATS; n++) begin
            if (n % CHUNK == 0) begin
                case ($urandom_range(0, 2))
                    0:       mode = MODE_FILL;
                    1:       mode = MODE_DRAIN;
                    default: mode = MODE_MIXED;
                endcase
                idle_on = ($urandom_range(0, 3) != 0);
            end
            send_beat(pick_action(mode), pick_word(),
                      idle_on ? $urandom_range(0, MAX_GAP) : 0);
        end
        start <= 1'b0;

        // Wait for the tail, then stay idle to catch any stray strobes
        while (sb.pending_views.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/dequ_pkg.sv
hw/rtl/dequ_ram.sv
hw/rtl/double_ended_queue_unit.sv
test/double_ended_queue_unit_tb.sv
